[hdl/ssem_pkg.sv]
package ssem_pkg;

	// operation field position inside an instruction word
	localparam int OPCODE_LSB = 13;

	// item kinds on the command channel
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_STEP = 1'b1;

	// instruction operation codes
	typedef enum logic [2:0] {
		OP_JMP     = 3'b000,
		OP_JRP     = 3'b001,
		OP_LDN     = 3'b010,
		OP_STO     = 3'b011,
		OP_SUB     = 3'b100,
		OP_SUB_ALT = 3'b101,
		OP_CMP     = 3'b110,
		OP_STP     = 3'b111
	} opcode_t;

	// shared adder modes
	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

endpackage

[hdl/ssem_in_if.sv]
interface ssem_in_if #(
	parameter int ADDR_W = 5
) ();
	logic              valid;
	logic              ready;
	logic              kind;
	logic [ADDR_W-1:0] load_address;
	logic [31:0]       load_word;

	modport source (output valid, output kind, output load_address, output load_word,
		input ready);
	modport sink (input valid, input kind, input load_address, input load_word,
		output ready);
endinterface

[hdl/ssem_out_if.sv]
interface ssem_out_if ();
	logic               valid;
	logic               ready;
	logic [31:0]        counter_value;
	logic [31:0]        instruction_word;
	logic signed [31:0] accumulator_value;
	logic               halted;
	logic               fault;

	modport source (output valid, output counter_value, output instruction_word,
		output accumulator_value, output halted, output fault, input ready);
	modport sink (input valid, input counter_value, input instruction_word,
		input accumulator_value, input halted, input fault, output ready);
endinterface

[hdl/ssem_fetch_execute_core.sv]
// load transaction: accept -> S_DONE -> result register; the next accept waits until the result loads
// step transaction: accept -> S_FETCH -> S_EXEC -> S_DONE -> result register, then the next accept
// a step that runs past the store faults in S_FETCH and goes from there to S_DONE
// steps while halted or faulted go from accept straight to S_DONE; a stalled result
// delays the next result load; the one store write port, one store read port and the one shared adder set the pace
// reset (arst_n low, asynchronous) clears the machine registers, then a sweep zeroes the store
// one word a cycle (all 2**ceil(log2(MEM_WORDS)) words, 32 by default) before cmd.ready rises
module ssem_fetch_execute_core #(
	parameter int MEM_WORDS = 32
) (
	input logic        clk,
	input logic        arst_n,
	ssem_in_if.sink    cmd,
	ssem_out_if.source res
);
	import ssem_pkg::*;

	localparam int AW    = $clog2(MEM_WORDS);
	localparam int DEPTH = 1 << AW;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_FETCH = 5'b00100,
		S_EXEC  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t        state_q;
	logic [AW-1:0] clr_idx_q;
	logic [31:0]   counter_q;
	logic [31:0]   instr_q;
	logic [31:0]   acc_q;
	logic          halt_q;
	logic          fault_q;
	logic          out_valid_q;

	logic [31:0]   mem [DEPTH];
	logic [31:0]   rd_data_q;

	logic          accept;
	logic          load_in_range;
	logic          oper_in_range;
	logic [AW-1:0] oper_addr;
	opcode_t       opcode;
	logic          out_load;

	alu_op_t       alu_op;
	logic [31:0]   alu_a;
	logic [31:0]   alu_b;
	logic [31:0]   alu_sum;
	logic          alu_carry;

	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [31:0]   mem_wd;
	logic [AW-1:0] rd_addr;

	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;

	// decode of the present instruction
	assign opcode        = opcode_t'(instr_q[OPCODE_LSB +: 3]);
	assign oper_addr     = instr_q[AW-1:0];
	assign oper_in_range = ({1'b0, oper_addr} < (AW+1)'(MEM_WORDS));
	assign load_in_range = ({1'b0, cmd.load_address} < (AW+1)'(MEM_WORDS));

	assign out_load = (state_q == S_DONE) && (!out_valid_q || res.ready);

	// shared adder operand selection
	always_comb begin
		alu_op = ALU_ADD;
		alu_a  = counter_q;
		alu_b  = 32'd1;
		case (state_q)
			S_FETCH: begin
				alu_b  = 32'(MEM_WORDS);
				alu_op = ALU_SUB;
			end
			S_EXEC: begin
				case (opcode)
					OP_JRP: begin
						alu_b = rd_data_q;
					end
					OP_LDN: begin
						alu_a  = '0;
						alu_b  = rd_data_q;
						alu_op = ALU_SUB;
					end
					OP_SUB, OP_SUB_ALT: begin
						alu_a  = acc_q;
						alu_b  = rd_data_q;
						alu_op = ALU_SUB;
					end
					default: begin
						alu_op = ALU_ADD;
					end
				endcase
			end
			default: begin
				alu_op = ALU_ADD;
			end
		endcase
	end

	ssem_alu u_alu (
		.op    (alu_op),
		.a     (alu_a),
		.b     (alu_b),
		.sum   (alu_sum),
		.carry (alu_carry)
	);

	// store write port: clearing sweep, load transaction or store instruction
	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_idx_q;
		mem_wd = '0;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_IDLE: begin
				mem_we = accept && (cmd.kind == KIND_LOAD) && load_in_range;
				mem_wa = cmd.load_address;
				mem_wd = cmd.load_word;
			end
			S_EXEC: begin
				mem_we = (opcode == OP_STO) && oper_in_range;
				mem_wa = oper_addr;
				mem_wd = acc_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// store read address: next instruction on accept, operand after fetch
	assign rd_addr = (state_q == S_FETCH) ? rd_data_q[AW-1:0] : alu_sum[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= mem[rd_addr];
	end

	// sequencer and machine registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_idx_q   <= '0;
			counter_q   <= '0;
			instr_q     <= '0;
			acc_q       <= '0;
			halt_q      <= 1'b0;
			fault_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + AW'(1);
					if (clr_idx_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (cmd.kind == KIND_STEP && !halt_q && !fault_q) begin
							counter_q <= alu_sum;
							state_q   <= S_FETCH;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_FETCH: begin
					// carry set: counter at or past the store size
					if (alu_carry) begin
						fault_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						instr_q <= rd_data_q;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (opcode)
						OP_JMP: counter_q <= rd_data_q;
						OP_JRP: counter_q <= alu_sum;
						OP_LDN, OP_SUB, OP_SUB_ALT: acc_q <= alu_sum;
						OP_CMP: begin
							if (acc_q[31]) begin
								counter_q <= alu_sum;
							end
						end
						OP_STP: halt_q <= 1'b1;
						default: begin
							halt_q <= halt_q;
						end
					endcase
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			res.counter_value     <= counter_q;
			res.instruction_word  <= instr_q;
			res.accumulator_value <= acc_q;
			res.halted            <= halt_q;
			res.fault             <= fault_q;
		end
	end

	assign res.valid = out_valid_q;

	// a halted machine keeps its counter and accumulator
	assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q && $stable(counter_q) && $stable(acc_q))
		else $error("halted machine changed state");

	// a fault freezes counter and instruction register
	assert property (@(posedge clk) disable iff (!arst_n)
		fault_q |=> fault_q && $stable(counter_q) && $stable(instr_q))
		else $error("faulted machine changed state");

	// a new result only appears out of the done state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside done state");

	// an accepted transaction either starts a fetch or finishes directly
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_FETCH) || (state_q == S_DONE))
		else $error("bad sequencer state after accept");
endmodule

[hdl/ssem_alu.sv]
module ssem_alu (
	input  ssem_pkg::alu_op_t op,
	input  logic [31:0]       a,
	input  logic [31:0]       b,
	output logic [31:0]       sum,
	output logic              carry
);
	import ssem_pkg::*;

	logic        sub;
	logic [31:0] b_eff;

	// subtract is add of the inverted operand plus one; carry set means a >= b
	assign sub   = (op == ALU_SUB);
	assign b_eff = sub ? ~b : b;
	assign {carry, sum} = {1'b0, a} + {1'b0, b_eff} + {32'd0, sub};
endmodule

[tb/sv/ssem_fetch_execute_checker.sv]
module ssem_fetch_execute_checker #(
	parameter int MEM_WORDS = 32,
	parameter int ADDR_W    = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	ssem_in_if          cmd,
	ssem_out_if         res,
	output int          errors,
	output int          pending,
	output int          accepted,
	output int          checked,
	output logic [31:0] counter_now,
	output logic [31:0] acc_now,
	output logic [7:0]  ops_run,
	output logic        halted_now,
	output logic        fault_now
);
	import ssem_pkg::*;

	// register view reported by one result transaction
	typedef struct packed {
		logic [31:0] counter;
		logic [31:0] instr;
		logic [31:0] acc;
		logic        halted;
		logic        fault;
	} machine_view_t;

	// shadow machine state
	logic [31:0]   store_m [MEM_WORDS];
	logic [31:0]   ctr_m;
	logic [31:0]   ir_m;
	logic [31:0]   acc_m;
	logic          halt_m;
	logic          fault_m;
	logic [7:0]    ops_m;
	int            err_count;
	int            in_count;
	int            out_count;
	machine_view_t view_q [$];

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			err_count++;
			$error("%s: expected %0h, got %0h", name, want, got);
		end
	endtask

	// one fetch-execute step of the machine
	task automatic run_step();
		opcode_t           op;
		logic [ADDR_W-1:0] a;
		logic [31:0]       s;
		if (halt_m || fault_m)
			return;
		ctr_m = ctr_m + 32'd1;
		if (ctr_m >= 32'(MEM_WORDS)) begin
			fault_m = 1'b1;
			return;
		end
		ir_m = store_m[ctr_m[ADDR_W-1:0]];
		op   = opcode_t'(ir_m[OPCODE_LSB +: 3]);
		a    = ir_m[ADDR_W-1:0];
		s    = (32'(a) < 32'(MEM_WORDS)) ? store_m[a] : 32'd0;
		ops_m[op] = 1'b1;
		case (op)
			OP_JMP: ctr_m = s;
			OP_JRP: ctr_m = ctr_m + s;
			OP_LDN: acc_m = 32'd0 - s;
			OP_STO: begin
				if (32'(a) < 32'(MEM_WORDS))
					store_m[a] = acc_m;
			end
			OP_SUB, OP_SUB_ALT: acc_m = acc_m - s;
			OP_CMP: begin
				if (acc_m[31])
					ctr_m = ctr_m + 32'd1;
			end
			default: halt_m = 1'b1;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		machine_view_t want;
		if (!arst_n) begin
			for (int i = 0; i < MEM_WORDS; i++)
				store_m[i] = '0;
			ctr_m     = '0;
			ir_m      = '0;
			acc_m     = '0;
			halt_m    = 1'b0;
			fault_m   = 1'b0;
			ops_m     = '0;
			err_count = 0;
			in_count  = 0;
			out_count = 0;
			view_q.delete();
		end else begin
			// result transaction against the oldest prediction
			if (res.valid && res.ready) begin
				out_count++;
				if (view_q.size() == 0) begin
					err_count++;
					$error("result transaction with no prediction waiting");
				end else begin
					want = view_q.pop_front();
					check_field("counter_value", want.counter, res.counter_value);
					check_field("instruction_word", want.instr, res.instruction_word);
					check_field("accumulator_value", want.acc, res.accumulator_value);
					check_field("halted", 32'(want.halted), 32'(res.halted));
					check_field("fault", 32'(want.fault), 32'(res.fault));
				end
			end
			// command transaction updates the shadow machine
			if (cmd.valid && cmd.ready) begin
				in_count++;
				if (cmd.kind == KIND_LOAD) begin
					if (32'(cmd.load_address) < 32'(MEM_WORDS))
						store_m[cmd.load_address] = cmd.load_word;
				end else begin
					run_step();
				end
				view_q.push_back('{ctr_m, ir_m, acc_m, halt_m, fault_m});
			end
		end
		errors      <= err_count;
		pending     <= view_q.size();
		accepted    <= in_count;
		checked     <= out_count;
		counter_now <= ctr_m;
		acc_now     <= acc_m;
		ops_run     <= ops_m;
		halted_now  <= halt_m;
		fault_now   <= fault_m;
	end

endmodule

[tb/sv/tb_ssem_fetch_execute_core.sv]
module tb_ssem_fetch_execute_core;
	import ssem_pkg::*;

	localparam int MEM_WORDS   = 32;
	localparam int ADDR_W      = 5;
	localparam int RAND_ITEMS  = 950;
	localparam int CYCLE_LIMIT = 250000;

	logic        clk = 1'b0;
	logic        arst_n;
	int          tx_idle_pct;
	int          rx_stall_pct;
	int          sent;
	int          cycles = 0;
	int          errors;
	int          pending;
	int          accepted;
	int          checked;
	logic [31:0] counter_now;
	logic [31:0] acc_now;
	logic [7:0]  ops_run;
	logic        halted_now;
	logic        fault_now;

	ssem_in_if #(.ADDR_W(ADDR_W)) cmd_if ();
	ssem_out_if res_if ();

	ssem_fetch_execute_core #(.MEM_WORDS(MEM_WORDS)) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_if),
		.res   (res_if)
	);

	ssem_fetch_execute_checker #(.MEM_WORDS(MEM_WORDS), .ADDR_W(ADDR_W)) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_if),
		.res        (res_if),
		.errors     (errors),
		.pending    (pending),
		.accepted   (accepted),
		.checked    (checked),
		.counter_now(counter_now),
		.acc_now    (acc_now),
		.ops_run    (ops_run),
		.halted_now (halted_now),
		.fault_now  (fault_now)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// result side back-pressure
	always @(posedge clk)
		res_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);

	// run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_ssem_fetch_execute_core: errors");
			$finish;
		end
	end

	// present one command transaction, with a random gap before it
	task automatic send_item(input logic kind, input logic [ADDR_W-1:0] addr,
		input logic [31:0] word);
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			cmd_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
		end
		cmd_if.valid        <= 1'b1;
		cmd_if.kind         <= kind;
		cmd_if.load_address <= addr;
		cmd_if.load_word    <= word;
		do @(posedge clk); while (!cmd_if.ready);
		sent++;
	endtask

	// let the shadow machine absorb every accepted transaction
	task automatic sync_model();
		cmd_if.valid <= 1'b0;
		do @(posedge clk); while (accepted != sent);
	endtask

	// hold the sender until every prediction has been matched
	task automatic drain_results();
		cmd_if.valid <= 1'b0;
		do @(posedge clk); while (accepted != sent || pending != 0);
	endtask

	// plant an instruction at the next counter value, maybe its operand, then step
	task automatic run_episode(input opcode_t op, input logic [ADDR_W-1:0] opnd_addr,
		input logic [31:0] opnd, input bit load_opnd, input logic [31:0] target);
		logic [31:0] pc;
		logic [31:0] w;
		pc = counter_now + 32'd1;
		w  = $urandom;
		w[OPCODE_LSB +: 3]  = op;
		w[ADDR_W-1:0]       = opnd_addr;
		if (op == OP_JMP)
			opnd = target;
		else if (op == OP_JRP)
			opnd = target - pc;
		if (load_opnd)
			send_item(KIND_LOAD, opnd_addr, opnd);
		send_item(KIND_LOAD, pc[ADDR_W-1:0], w);
		send_item(KIND_STEP, ADDR_W'($urandom), $urandom);
		sync_model();
	endtask

	// random well-formed episode that keeps the machine running
	task automatic random_episode();
		logic [31:0]       pc;
		logic [31:0]       tgt;
		logic [31:0]       d;
		logic [ADDR_W-1:0] a;
		opcode_t           op;
		bit                ld;
		pc = counter_now + 32'd1;
		op = opcode_t'($urandom_range(0, 6));
		// last word: only a jump keeps the counter inside the store
		if (pc == 32'(MEM_WORDS - 1))
			op = $urandom_range(0, 1) ? OP_JRP : OP_JMP;
		if (pc == 32'(MEM_WORDS - 2) && acc_now[31] && op == OP_CMP)
			op = OP_SUB;
		a = ADDR_W'($urandom);
		if ((op == OP_JMP || op == OP_JRP) && a == pc[ADDR_W-1:0])
			a = a + ADDR_W'(1);
		tgt = ($urandom_range(0, 15) == 0) ? '1 : 32'($urandom_range(0, MEM_WORDS - 2));
		case ($urandom_range(0, 9))
			0: d = 32'h0000_0000;
			1: d = 32'h0000_0001;
			2: d = 32'h7FFF_FFFF;
			3: d = 32'h8000_0000;
			4: d = 32'hFFFF_FFFF;
			default: d = $urandom;
		endcase
		ld = (op == OP_JMP || op == OP_JRP) ||
			($urandom_range(0, 1) == 1 && a != pc[ADDR_W-1:0]);
		// stray store writes between episodes
		if ($urandom_range(0, 4) == 0)
			send_item(KIND_LOAD, ADDR_W'($urandom), $urandom);
		run_episode(op, a, d, ld, tgt);
	endtask

	initial begin
		int          base;
		logic [31:0] tgt;
		arst_n              <= 1'b0;
		cmd_if.valid        <= 1'b0;
		cmd_if.kind         <= KIND_LOAD;
		cmd_if.load_address <= '0;
		cmd_if.load_word    <= '0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		sent         = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: step on a cleared store, field extremes, every running opcode
		send_item(KIND_STEP, '1, '1);
		sync_model();
		send_item(KIND_LOAD, 5'd31, 32'hFFFF_FFFF);
		send_item(KIND_LOAD, 5'd0, 32'h0000_0000);
		run_episode(OP_LDN, 5'd31, '0, 1'b0, '0);
		run_episode(OP_SUB, 5'd3, 32'h8000_0000, 1'b1, '0);
		// negative accumulator takes the skip
		run_episode(OP_CMP, 5'd7, '0, 1'b0, '0);
		run_episode(OP_STO, 5'd9, '0, 1'b0, '0);
		run_episode(OP_SUB_ALT, 5'd9, '0, 1'b0, '0);
		// zero accumulator does not skip
		run_episode(OP_CMP, 5'd9, '0, 1'b0, '0);
		run_episode(OP_JMP, 5'd12, '0, 1'b1, 32'd25);
		// backward relative jump to all ones, counter wraps to zero on the next step
		run_episode(OP_JRP, 5'd13, '0, 1'b1, '1);
		// word zero executes and reads itself as operand
		run_episode(OP_LDN, 5'd0, '0, 1'b0, '0);

		// random phases: no idling, sender idle, receiver stall, both
		base = sent;
		for (int ph = 0; ph < 4; ph++) begin
			tx_idle_pct  = (ph == 1) ? 67 : (ph == 3) ? 33 : 0;
			rx_stall_pct = (ph == 2) ? 67 : (ph == 3) ? 33 : 0;
			while (sent - base < RAND_ITEMS * (ph + 1) / 4)
				random_episode();
			drain_results();
		end

		// end state: either a halt or a counter past the store, then dead steps
		tx_idle_pct  = 33;
		rx_stall_pct = 33;
		if ($urandom_range(0, 1) == 1) begin
			run_episode(OP_STP, ADDR_W'($urandom), '0, 1'b0, '0);
		end else begin
			tgt = $urandom_range(0, 1) ? 32'(MEM_WORDS - 1) :
				(32'h8000_0000 | ($urandom & 32'h7FFF_FFFE));
			run_episode(OP_JMP, counter_now[ADDR_W-1:0] + ADDR_W'(2), '0, 1'b1, tgt);
		end
		repeat (4) begin
			send_item(KIND_STEP, ADDR_W'($urandom), $urandom);
			send_item(KIND_LOAD, ADDR_W'($urandom), $urandom);
		end

		drain_results();
		repeat (16) @(posedge clk);
		$display("run: %0d command transactions, %0d results compared", sent, checked);
		$display("opcodes executed (bit per code) %b, ended halted=%0b faulted=%0b",
			ops_run, halted_now, fault_now);
		if (errors == 0)
			$display("tb_ssem_fetch_execute_core: clean");
		else
			$display("tb_ssem_fetch_execute_core: errors");
		$finish;
	end

endmodule

[filelist.f]
hdl/ssem_pkg.sv
hdl/ssem_in_if.sv
hdl/ssem_out_if.sv
hdl/ssem_alu.sv
hdl/ssem_fetch_execute_core.sv
tb/sv/ssem_fetch_execute_checker.sv
tb/sv/tb_ssem_fetch_execute_core.sv
